/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition in the next cycle follows from a trigger
`define ASSERT_NEXT(label, trig, cons, msg) \
   `ASSERT_CLK(label, (trig) |=> (cons), msg)

`endif

/* rtl/lsfb_pkg.sv */
// Types, constants and the control store of the LED serial frame builder
package lsfb_pkg;

   localparam int MAX_LEDS  = 512;
   localparam int LED_W     = 10;
   localparam int TAIL_W    = $clog2((MAX_LEDS + 15) / 16);
   localparam int PC_W      = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 10;

   localparam logic [CSR_IDX_W-1:0] REG_LED_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MODE        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WHITE_CAL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WHITE_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WHITE_RED   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WHITE_GREEN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WHITE_BLUE  = 3'd6;

   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_EXT   = 2'd1;
   localparam logic [1:0] MODE_APA   = 2'd2;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_D = 8'h64;
   localparam logic [7:0] CH_LOWER_W = 8'h77;
   localparam logic [7:0] HDR_XOR    = 8'h55;
   localparam logic [7:0] CHK_AVOID  = 8'h41;
   localparam logic [7:0] CHK_SUBST  = 8'haa;
   localparam logic [7:0] APA_MARK   = 8'hff;
   localparam logic [8:0] MOD_255    = 9'd255;

   // byte sources
   localparam logic [4:0] SRC_A     = 5'd0;
   localparam logic [4:0] SRC_MODE  = 5'd1;
   localparam logic [4:0] SRC_CAL   = 5'd2;
   localparam logic [4:0] SRC_HI    = 5'd3;
   localparam logic [4:0] SRC_LO    = 5'd4;
   localparam logic [4:0] SRC_CHK   = 5'd5;
   localparam logic [4:0] SRC_RED   = 5'd6;
   localparam logic [4:0] SRC_GREEN = 5'd7;
   localparam logic [4:0] SRC_BLUE  = 5'd8;
   localparam logic [4:0] SRC_WL    = 5'd9;
   localparam logic [4:0] SRC_WR    = 5'd10;
   localparam logic [4:0] SRC_WG    = 5'd11;
   localparam logic [4:0] SRC_WB    = 5'd12;
   localparam logic [4:0] SRC_SUM   = 5'd13;
   localparam logic [4:0] SRC_SOS   = 5'd14;
   localparam logic [4:0] SRC_PXR   = 5'd15;
   localparam logic [4:0] SRC_ZERO  = 5'd16;
   localparam logic [4:0] SRC_MARK  = 5'd17;

   // branch conditions
   localparam logic [2:0] C_NEVER    = 3'd0;
   localparam logic [2:0] C_ALWAYS   = 3'd1;
   localparam logic [2:0] C_NOT_LAST = 3'd2;
   localparam logic [2:0] C_NOT_CAL  = 3'd3;
   localparam logic [2:0] C_CNT_ZERO = 3'd4;
   localparam logic [2:0] C_MODE     = 3'd5;

   localparam logic [PC_W-1:0] PC_HDR       = 5'd0;
   localparam logic [PC_W-1:0] PC_PLAIN     = 5'd6;
   localparam logic [PC_W-1:0] PC_EXT       = 5'd9;
   localparam logic [PC_W-1:0] PC_EXT_TRAIL = 5'd16;
   localparam logic [PC_W-1:0] PC_APA_ZERO  = 5'd19;
   localparam logic [PC_W-1:0] PC_APA_BODY  = 5'd23;
   localparam logic [PC_W-1:0] PC_TAIL      = 5'd27;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic [4:0]      src;
      logic            hash;
      logic            load_cnt;
      logic            dec_cnt;
      logic [2:0]      end_cond;
      logic [2:0]      jmp_cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   function automatic ucode_type uw(input logic [4:0] src, input logic hash,
                                    input logic ld, input logic dec,
                                    input logic [2:0] ec, input logic [2:0] jc,
                                    input logic [PC_W-1:0] tgt);
      ucode_type w;
      w.src      = src;
      w.hash     = hash;
      w.load_cnt = ld;
      w.dec_cnt  = dec;
      w.end_cond = ec;
      w.jmp_cond = jc;
      w.target   = tgt;
      return w;
   endfunction

   // control store: every step emits one byte, then ends, jumps or advances
   function automatic ucode_type ucode(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         5'd0:  w = uw(SRC_A,     1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd1:  w = uw(SRC_MODE,  1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd2:  w = uw(SRC_CAL,   1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd3:  w = uw(SRC_HI,    1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd4:  w = uw(SRC_LO,    1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd5:  w = uw(SRC_CHK,   1'b0, 1'b0, 1'b0, C_NEVER,    C_MODE,   PC_HDR);
         5'd6:  w = uw(SRC_RED,   1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd7:  w = uw(SRC_GREEN, 1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd8:  w = uw(SRC_BLUE,  1'b0, 1'b0, 1'b0, C_ALWAYS,   C_NEVER,  PC_HDR);
         5'd9:  w = uw(SRC_RED,   1'b1, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd10: w = uw(SRC_GREEN, 1'b1, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd11: w = uw(SRC_BLUE,  1'b1, 1'b0, 1'b0, C_NOT_LAST, C_NOT_CAL,
                       PC_EXT_TRAIL);
         5'd12: w = uw(SRC_WL,    1'b1, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd13: w = uw(SRC_WR,    1'b1, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd14: w = uw(SRC_WG,    1'b1, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd15: w = uw(SRC_WB,    1'b1, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd16: w = uw(SRC_SUM,   1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd17: w = uw(SRC_SOS,   1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd18: w = uw(SRC_PXR,   1'b0, 1'b0, 1'b0, C_ALWAYS,   C_NEVER,  PC_HDR);
         5'd19: w = uw(SRC_ZERO,  1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd20: w = uw(SRC_ZERO,  1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd21: w = uw(SRC_ZERO,  1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd22: w = uw(SRC_ZERO,  1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd23: w = uw(SRC_MARK,  1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd24: w = uw(SRC_RED,   1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd25: w = uw(SRC_GREEN, 1'b0, 1'b0, 1'b0, C_NEVER,    C_NEVER,  PC_HDR);
         5'd26: w = uw(SRC_BLUE,  1'b0, 1'b1, 1'b0, C_NOT_LAST, C_NEVER,  PC_HDR);
         5'd27: w = uw(SRC_ZERO,  1'b0, 1'b0, 1'b1, C_CNT_ZERO, C_ALWAYS, PC_TAIL);
         default: w = uw(SRC_ZERO, 1'b0, 1'b0, 1'b0, C_ALWAYS,  C_NEVER,  PC_HDR);
      endcase
      return w;
   endfunction

   // body entry for the mode, after the header or for a later color of the frame
   function automatic logic [PC_W-1:0] mode_entry(input logic [1:0] mode,
                                                  input logic first);
      logic [PC_W-1:0] pc;
      case (mode)
         MODE_EXT: pc = PC_EXT;
         MODE_APA: pc = first ? PC_APA_ZERO : PC_APA_BODY;
         default:  pc = PC_PLAIN;
      endcase
      return pc;
   endfunction

endpackage

/* rtl/led_serial_frame_builder.sv */
// LED serial frame builder: microcoded byte sequencer with output register
//
// Usage: req_valid/req_ready/req_data take one LED color per beat; rsp_valid/
// rsp_ready/rsp_data hand out the frame one byte per beat, with last_of_run on
// the final byte caused by a color and frame_end on the final byte of a frame.
// The csr_ channel writes the seven configuration registers by index; it is
// always ready. The user must write it only while no color is in flight; the
// block itself does not enforce this. A color is taken when the sequencer is
// idle. Each control step emits one byte: a color causes three bytes in plain
// mode, three for a mid-frame color in extended mode and four in APA102 mode,
// more on the first and last colors of a frame (header, start/end frame,
// calibration and check bytes). The color is registered with the sequencer
// state, and its bytes then pass through the output register to rsp_.
// The byte rate is one control-store step per cycle while rsp_ is not stalled.
// A stalled receiver holds the output register, and the sequencer waits with
// it; the next color is taken as soon as the last step of the current one has
// loaded its byte. Reset (synchronous) empties the output register, returns to
// idle, clears the LED index and check sums and loads the register defaults.
module led_serial_frame_builder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  lsfb_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output lsfb_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lsfb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lsfb_pkg::CSR_DAT_W-1:0]   csr_data
);
   import lsfb_pkg::*;

   logic [LED_W-1:0]  led_count_ff;
   logic [1:0]        mode_ff;
   logic              white_cal_ff;
   logic [7:0]        white_limit_ff, white_red_ff, white_green_ff, white_blue_ff;

   logic              busy_ff, busy_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic              last_ff;
   req_type           color_ff;
   logic [TAIL_W-1:0] cnt_ff, cnt_in;

   logic [LED_W-1:0]  led_index_ff, led_index_in;
   logic [7:0]        sum_ff, sum_in, sos_ff, sos_in, pxr_ff, pxr_in, pos_ff, pos_in;

   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              req_go, step_go, end_hit, jmp_hit, ext, apa;
   ucode_type         uc;
   logic [LED_W-1:0]  n_eff, cnt_hdr;
   logic [LED_W:0]    idx_next, endlen_raw;
   logic [TAIL_W-1:0] endlen_m1;
   logic [7:0]        emit_byte, hi, lo, hx;
   logic [8:0]        sum_raw, sos_raw, pxr_raw;

   assign req_ready = !busy_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign req_go    = req_valid && req_ready;
   assign step_go   = busy_ff && (!out_valid_ff || rsp_ready);
   assign uc        = ucode(pc_ff);
   assign ext       = (mode_ff == MODE_EXT);
   assign apa       = (mode_ff == MODE_APA);

   always_comb begin
      if (led_count_ff == '0) begin
         n_eff = LED_W'(1);
      end else if (led_count_ff > LED_W'(MAX_LEDS)) begin
         n_eff = LED_W'(MAX_LEDS);
      end else begin
         n_eff = led_count_ff;
      end
      idx_next   = {1'b0, led_index_ff} + (LED_W+1)'(1);
      cnt_hdr    = apa ? n_eff : n_eff - LED_W'(1);
      hi         = 8'(cnt_hdr >> 8);
      lo         = cnt_hdr[7:0];
      endlen_raw = ({1'b0, n_eff} + (LED_W+1)'(15)) >> 4;
      if (endlen_raw < (LED_W+1)'(4)) begin
         endlen_m1 = TAIL_W'(3);
      end else begin
         endlen_m1 = TAIL_W'(endlen_raw - (LED_W+1)'(1));
      end
   end

   always_comb begin
      case (uc.src)
         SRC_A:     emit_byte = CH_UPPER_A;
         SRC_MODE:  emit_byte = ext ? CH_LOWER_W : CH_LOWER_D;
         SRC_CAL:   emit_byte = (ext && white_cal_ff) ? CH_UPPER_A : CH_LOWER_A;
         SRC_HI:    emit_byte = hi;
         SRC_LO:    emit_byte = lo;
         SRC_CHK:   emit_byte = hi ^ lo ^ HDR_XOR;
         SRC_RED:   emit_byte = color_ff.red;
         SRC_GREEN: emit_byte = color_ff.green;
         SRC_BLUE:  emit_byte = color_ff.blue;
         SRC_WL:    emit_byte = white_limit_ff;
         SRC_WR:    emit_byte = white_red_ff;
         SRC_WG:    emit_byte = white_green_ff;
         SRC_WB:    emit_byte = white_blue_ff;
         SRC_SUM:   emit_byte = sum_ff;
         SRC_SOS:   emit_byte = sos_ff;
         SRC_PXR:   emit_byte = (pxr_ff != CHK_AVOID) ? pxr_ff : CHK_SUBST;
         SRC_MARK:  emit_byte = APA_MARK;
         default:   emit_byte = 8'h00;
      endcase
   end

   function automatic logic cond_hit(input logic [2:0] c, input logic last,
                                     input logic cal, input logic cz);
      logic r;
      case (c)
         C_ALWAYS:   r = 1'b1;
         C_NOT_LAST: r = !last;
         C_NOT_CAL:  r = !cal;
         C_CNT_ZERO: r = cz;
         C_MODE:     r = 1'b1;
         default:    r = 1'b0;
      endcase
      return r;
   endfunction

   assign end_hit = cond_hit(uc.end_cond, last_ff, white_cal_ff, cnt_ff == '0);
   assign jmp_hit = cond_hit(uc.jmp_cond, last_ff, white_cal_ff, cnt_ff == '0);

   // running mod-255 sums over hashed bytes
   always_comb begin
      hx      = emit_byte ^ pos_ff;
      sum_raw = {1'b0, sum_ff} + {1'b0, emit_byte};
      if (sum_raw >= MOD_255) begin
         sum_raw = sum_raw - MOD_255;
      end
      sos_raw = {1'b0, sos_ff} + sum_raw;
      if (sos_raw >= MOD_255) begin
         sos_raw = sos_raw - MOD_255;
      end
      pxr_raw = {1'b0, pxr_ff} + {1'b0, hx};
      if (pxr_raw >= MOD_255) begin
         pxr_raw = pxr_raw - MOD_255;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      led_index_in = led_index_ff;
      sum_in       = sum_ff;
      sos_in       = sos_ff;
      pxr_in       = pxr_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      if (req_go) begin
         busy_in = 1'b1;
         pc_in   = (led_index_ff == '0) ? PC_HDR : mode_entry(mode_ff, 1'b0);
      end
      if (step_go) begin
         out_valid_in       = 1'b1;
         out_in.out_byte    = emit_byte;
         out_in.last_of_run = end_hit;
         out_in.frame_end   = end_hit && last_ff;
         if (uc.load_cnt) begin
            cnt_in = endlen_m1;
         end else if (uc.dec_cnt) begin
            cnt_in = cnt_ff - TAIL_W'(1);
         end
         if (uc.hash) begin
            sum_in = sum_raw[7:0];
            sos_in = sos_raw[7:0];
            pxr_in = pxr_raw[7:0];
            pos_in = pos_ff + 8'd1;
         end
         if (end_hit) begin
            busy_in = 1'b0;
            if (last_ff) begin
               led_index_in = '0;
               sum_in       = '0;
               sos_in       = '0;
               pxr_in       = '0;
               pos_in       = '0;
            end else begin
               led_index_in = idx_next[LED_W-1:0];
            end
         end else if (jmp_hit) begin
            pc_in = (uc.jmp_cond == C_MODE) ? mode_entry(mode_ff, 1'b1) : uc.target;
         end else begin
            pc_in = pc_ff + PC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         pc_ff          <= PC_HDR;
         out_valid_ff   <= 1'b0;
         led_index_ff   <= '0;
         sum_ff         <= '0;
         sos_ff         <= '0;
         pxr_ff         <= '0;
         pos_ff         <= '0;
         cnt_ff         <= '0;
         led_count_ff   <= LED_W'(1);
         mode_ff        <= MODE_PLAIN;
         white_cal_ff   <= 1'b0;
         white_limit_ff <= 8'hff;
         white_red_ff   <= 8'hff;
         white_green_ff <= 8'hff;
         white_blue_ff  <= 8'hff;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         out_valid_ff <= out_valid_in;
         led_index_ff <= led_index_in;
         sum_ff       <= sum_in;
         sos_ff       <= sos_in;
         pxr_ff       <= pxr_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LED_COUNT:   led_count_ff   <= csr_data[LED_W-1:0];
               REG_MODE:        mode_ff        <= csr_data[1:0];
               REG_WHITE_CAL:   white_cal_ff   <= csr_data[0];
               REG_WHITE_LIMIT: white_limit_ff <= csr_data[7:0];
               REG_WHITE_RED:   white_red_ff   <= csr_data[7:0];
               REG_WHITE_GREEN: white_green_ff <= csr_data[7:0];
               REG_WHITE_BLUE:  white_blue_ff  <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   // hold the color and its frame position for the whole run, and load the output byte
   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (req_go) begin
         color_ff <= req_data;
         last_ff  <= (idx_next >= {1'b0, n_eff});
      end
   end

`include "assert_macros.svh"

   `ASSERT_NEXT(a_pc_hold, busy_ff && out_valid_ff && !rsp_ready, $stable(pc_ff), "pc moved while output stalled")
   `ASSERT_NEXT(a_end_idle, step_go && end_hit, !busy_ff && out_valid_ff && rsp_data.last_of_run, "run end not delivered")
   `ASSERT_CLK(a_tail_apa, (busy_ff && pc_ff == PC_TAIL) |-> apa, "end frame outside APA102 mode")
   `ASSERT_CLK(a_frame_end_run, (rsp_valid && rsp_data.frame_end) |-> rsp_data.last_of_run, "frame end without run end")

endmodule
